FILE: design/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared widths and codes for the table linear interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int WL_W  = 32;
  localparam int VAL_W = 32;
  localparam int NP_W  = 9;
  localparam int IDX_W = 8;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;
endpackage

FILE: design/table_linear_interpolator.sv
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear lookup over a table of (wavelength, real, imag) points.
// ----------------------------------------------------------------------------
// A write beat loads one table slot and produces no result. A query beat
// reads the two end points of the table, then runs a binary search with one
// table memory read per step (ceil(log2(N-1)) steps, each a check of the
// interval, the read of the middle entry and the compare once the registered
// read data is back). It then reads the two segment points, forms both
// products with two 32x32 multipliers, and divides both 64-bit products by
// the segment width with two restoring dividers (the products are formed in
// the first divider step, then one quotient bit per cycle). An out-of-range
// query ends once the end points are read. The table lives in one single-port
// memory with a registered read port; unwritten entries read as undefined
// data. The block works on one beat at a time and accepts the next beat
// whenever it is back in its idle state. A finished result waits in the
// output register; a later query that finishes while that register is still
// occupied holds in its last step until the result beat has been taken.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data,        // num_points
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: entry_index[7:0], entry_wavelength[39:8], entry_real[71:40],
  // entry_imag[103:72], query_wavelength[135:104]
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tuser,    // tuser: op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: real_out[31:0], imag_out[63:32], segment[71:64], out_of_range[72]
  output logic [79:0]  m_axis_tdata
);
  localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RDN, S_CHK, S_MID, S_MIDW, S_RDL, S_RDU, S_MUL, S_DIV, S_DONE
  } state_t;

  state_t state_r;
  logic [95:0] mem [TABLE_DEPTH];
  logic [95:0] rd_r;
  logic [AW-1:0] raddr;
  logic          ren;

  logic [8:0]  np_r;
  logic [CW-1:0] n_eff, lo_r, hi_r, mid;
  logic [31:0] q_r, wl0_r, wll_r, d_r, a_r;
  logic signed [32:0] re1_r, im1_r;
  logic        rneg_r, ineg_r;
  logic [63:0] rrem_r, irem_r;
  logic [31:0] rquo_r, iquo_r, rmag_r, imag_r;
  logic [5:0]  cnt_r;
  logic        ovalid_r;
  logic [79:0] odata_r;

  // Saturate the point count to the table span.
  always_comb begin
    if (np_r < 9'd2) n_eff = CW'(2);
    else if ({{(32-tli_pkg::NP_W){1'b0}}, np_r} > 32'(TABLE_DEPTH)) n_eff = CW'(TABLE_DEPTH);
    else n_eff = CW'(np_r);
  end
  assign mid = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state_r == S_IDLE);
  assign m_axis_tvalid = ovalid_r;
  assign m_axis_tdata  = odata_r;

  wire acc = s_axis_tvalid && s_axis_tready;
  wire wr_en = acc && (s_axis_tuser == tli_pkg::OP_WRITE) &&
               ({24'd0, s_axis_tdata[7:0]} < 32'(TABLE_DEPTH));

  // The output register can take a new result when empty or being drained.
  wire out_free = !ovalid_r || m_axis_tready;
  wire oor_hit  = (q_r < wl0_r) || (q_r >= rd_r[31:0]);
  wire emit_oor = (state_r == S_RDN) && oor_hit && out_free;
  wire emit_res = (state_r == S_DONE) && (cnt_r == 6'd33) && out_free;

  always_comb begin
    ren = 1'b1;
    case (state_r)
      S_IDLE:  raddr = '0;
      S_RD0:   raddr = AW'(n_eff - CW'(1));
      S_MID:   raddr = AW'(mid);
      S_RDL:   raddr = AW'(lo_r + CW'(1));
      default: begin raddr = AW'(lo_r); ren = 1'b0; end
    endcase
    if (state_r == S_CHK) ren = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(s_axis_tdata[7:0])] <= s_axis_tdata[103:8];
    else if (ren) rd_r <= mem[raddr];
  end

  // Value delta magnitude and sign of the upper point against the lower one.
  logic signed [33:0] dre, dim;
  assign dre = 34'(signed'(rd_r[63:32])) - 34'(re1_r);
  assign dim = 34'(signed'(rd_r[95:64])) - 34'(im1_r);
  logic [64:0] rtry, itry;
  assign rtry = {rrem_r, 1'b0} - {1'b0, d_r, 32'd0};
  assign itry = {irem_r, 1'b0} - {1'b0, d_r, 32'd0};
  logic signed [33:0] rres, ires;
  assign rres = rneg_r ? 34'(re1_r) - 34'({1'b0, rquo_r}) : 34'(re1_r) + 34'({1'b0, rquo_r});
  assign ires = ineg_r ? 34'(im1_r) - 34'({1'b0, iquo_r}) : 34'(im1_r) + 34'({1'b0, iquo_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      np_r <= 9'd2;
      ovalid_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      if (cfg_valid && cfg_ready) np_r <= cfg_data;
      if (emit_oor || emit_res) ovalid_r <= 1'b1;
      else if (m_axis_tready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (acc) begin
          q_r <= s_axis_tdata[135:104];
          state_r <= (s_axis_tuser == tli_pkg::OP_QUERY) ? S_RD0 : S_DONE;
        end
        S_RD0: begin wl0_r <= rd_r[31:0]; state_r <= S_RDN; end
        S_RDN: begin
          lo_r <= '0; hi_r <= n_eff - CW'(1);
          if (!oor_hit) state_r <= S_CHK;
          else if (out_free) begin
            odata_r <= {7'd0, 1'b1, 72'd0};
            state_r <= S_IDLE;
          end
        end
        S_CHK: state_r <= (hi_r - lo_r > CW'(1)) ? S_MID : S_RDU;
        S_MID: state_r <= S_MIDW;
        S_MIDW: begin
          if (q_r < rd_r[31:0]) hi_r <= AW'(0) + mid; else lo_r <= mid;
          state_r <= S_CHK;
        end
        S_RDU: state_r <= S_RDL;
        S_RDL: begin
          wll_r <= rd_r[31:0];
          a_r <= q_r - rd_r[31:0];
          re1_r <= 33'(signed'(rd_r[63:32]));
          im1_r <= 33'(signed'(rd_r[95:64]));
          state_r <= S_MUL;
        end
        S_MUL: begin
          d_r <= rd_r[31:0] - wll_r;
          rneg_r <= dre < 0; ineg_r <= dim < 0;
          rmag_r <= 32'(dre < 0 ? -dre : dre);
          imag_r <= 32'(dim < 0 ? -dim : dim);
          cnt_r <= 6'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == 6'd0) begin
            rrem_r <= 64'(a_r) * 64'(rmag_r);
            irem_r <= 64'(a_r) * 64'(imag_r);
          end else begin
            rquo_r <= {rquo_r[30:0], !rtry[64]};
            iquo_r <= {iquo_r[30:0], !itry[64]};
            rrem_r <= rtry[64] ? {rrem_r[62:0], 1'b0} : rtry[63:0];
            irem_r <= itry[64] ? {irem_r[62:0], 1'b0} : itry[63:0];
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd32) state_r <= S_DONE;
        end
        S_DONE: begin
          // A write arrives here with the counter cleared; a query with 33.
          if (cnt_r != 6'd33) state_r <= S_IDLE;
          else if (out_free) begin
            odata_r <= {7'd0, 1'b0, 8'(lo_r), ires[31:0], rres[31:0]};
            cnt_r <= 6'd0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: design/tli_checker.sv
// ----------------------------------------------------------------------------
// tli_assertions
// Port-level checks for the table linear interpolator.
// ----------------------------------------------------------------------------
module tli_assertions (
  input logic        clk,
  input logic        rst_n,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_oor: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tdata[72] |-> m_axis_tdata[71:0] == 72'd0)
    else $error("out-of-range result carries data");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted two beats back to back");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result issued while a beat is still in progress");
endmodule

bind table_linear_interpolator tli_assertions u_tli_assertions (.*);

FILE: bench/tli_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_checker
// Watches the table linear interpolator's channels, predicts each query
// result from its own copy of the point table and compares all fields at once.
// ----------------------------------------------------------------------------
module tli_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [8:0]   cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [79:0]  m_axis_tdata,
  output int           fail_count,
  output int           pending_results
);
  typedef struct packed {
    logic        out_of_range;
    logic [7:0]  segment;
    logic [31:0] imag_out;
    logic [31:0] real_out;
  } interp_result_t;

  logic [31:0] wl_tbl [256];
  logic [31:0] re_tbl [256];
  logic [31:0] im_tbl [256];
  logic [8:0]  point_count;
  interp_result_t expected_q [$];

  function automatic logic [31:0] lerp_value(logic [31:0] v1, logic [31:0] v2,
                                             logic [31:0] a, logic [31:0] d);
    longint dv;
    longint unsigned mag;
    longint unsigned quo;
    longint r;
    dv = longint'($signed(v2)) - longint'($signed(v1));
    mag = (dv < 0) ? longint'(-dv) : dv;
    quo = (longint'(a) * mag) / longint'(d);
    r = (dv < 0) ? longint'($signed(v1)) - longint'(quo)
                 : longint'($signed(v1)) + longint'(quo);
    return r[31:0];
  endfunction

  function automatic interp_result_t lookup_point(logic [31:0] q);
    interp_result_t res;
    int n;
    int lo;
    int hi;
    int mid;
    logic [31:0] d;
    logic [31:0] a;
    n = point_count;
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    lo = 0;
    hi = n - 1;
    res = '0;
    if (q < wl_tbl[0] || q >= wl_tbl[hi]) begin
      res.out_of_range = 1'b1;
      return res;
    end
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (q < wl_tbl[mid]) hi = mid;
      else lo = mid;
    end
    d = wl_tbl[lo + 1] - wl_tbl[lo];
    a = q - wl_tbl[lo];
    res.real_out = lerp_value(re_tbl[lo], re_tbl[lo + 1], a, d);
    res.imag_out = lerp_value(im_tbl[lo], im_tbl[lo + 1], a, d);
    res.segment = lo[7:0];
    return res;
  endfunction

  always @(posedge clk) begin
    interp_result_t got;
    interp_result_t want;
    if (!rst_n) begin
      point_count <= 9'd2;
      fail_count <= 0;
      pending_results <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) point_count <= cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == tli_pkg::OP_WRITE) begin
          wl_tbl[s_axis_tdata[7:0]] = s_axis_tdata[39:8];
          re_tbl[s_axis_tdata[7:0]] = s_axis_tdata[71:40];
          im_tbl[s_axis_tdata[7:0]] = s_axis_tdata[103:72];
        end else begin
          expected_q.push_back(lookup_point(s_axis_tdata[135:104]));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[72:0];
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display(
                "mismatch: exp re=%h im=%h seg=%0d oor=%b, got re=%h im=%h seg=%0d oor=%b",
                want.real_out, want.imag_out, want.segment, want.out_of_range,
                got.real_out, got.imag_out, got.segment, got.out_of_range);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_results <= expected_q.size();
    end
  end
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the table linear interpolator.
// ----------------------------------------------------------------------------
// Tables are loaded with strictly increasing wavelengths, then queried inside
// and outside the span under random gaps on both channels. The point count is
// changed only when the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [8:0]   cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [79:0]  m_axis_tdata;
  int           fail_count;
  int           pending_results;
  int           cycle_count;
  int           sent_items;
  int           sink_wait;
  int           next_gap;
  logic [31:0]  wl_shadow [256];
  int           loaded_points;

  table_linear_interpolator dut (.*);
  tli_checker chk (.*);

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Result side: random stall per beat, sometimes a stretch of none at all.
  always @(posedge clk) begin
    if (!rst_n) begin
      m_axis_tready <= 1'b0;
      sink_wait <= 0;
    end else if (sink_wait > 0) begin
      sink_wait <= sink_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (m_axis_tvalid && m_axis_tready)
        sink_wait <= ((cycle_count / 4000) % 3 == 0) ? 0 : $urandom_range(0, 19);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("table_linear_interpolator test failed");
      $finish;
    end
  end

  // The gap before the next beat is drawn once a beat is taken; with no gap
  // valid stays high and the next call puts new data on the bus at once.
  task automatic send_beat(logic op, logic [7:0] idx, logic [31:0] wl, logic [31:0] re,
                           logic [31:0] im, logic [31:0] q);
    repeat (next_gap) @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {q, im, re, wl, idx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_items++;
    next_gap = ((sent_items / 100) % 4 == 1) ? 0 : $urandom_range(0, 19);
    if (next_gap > 0) s_axis_tvalid <= 1'b0;
  endtask

  // Drops valid when a beat was left open without a gap.
  task automatic idle_input();
    if (next_gap == 0) begin
      s_axis_tvalid <= 1'b0;
      next_gap = 1;
    end
  endtask

  task automatic write_point(int idx, logic [31:0] wl, logic [31:0] re, logic [31:0] im);
    send_beat(tli_pkg::OP_WRITE, idx[7:0], wl, re, im, $urandom);
    wl_shadow[idx[7:0]] = wl;
  endtask

  task automatic query_at(logic [31:0] q);
    send_beat(tli_pkg::OP_QUERY, 8'($urandom), $urandom, $urandom, $urandom, q);
  endtask

  task automatic set_points(int n);
    idle_input();
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= n[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fills slots 0..n-1 with increasing wavelengths starting at base.
  task automatic load_table(int n, logic [31:0] base, int max_step);
    logic [31:0] wl;
    wl = base;
    for (int i = 0; i < n; i++) begin
      write_point(i, wl, $urandom, $urandom);
      wl = wl + $urandom_range(1, max_step);
    end
    loaded_points = n;
  endtask

  task automatic random_query();
    logic [31:0] lo_wl;
    logic [31:0] hi_wl;
    lo_wl = wl_shadow[0];
    hi_wl = wl_shadow[8'(loaded_points - 1)];
    case ($urandom_range(0, 9))
      0: query_at($urandom);
      1: query_at(hi_wl);
      2: query_at(lo_wl);
      3: query_at(wl_shadow[8'($urandom_range(0, loaded_points - 1))]);
      default: query_at(32'(lo_wl + ({$urandom, $urandom} % (64'(hi_wl) - lo_wl))));
    endcase
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = tli_pkg::OP_WRITE;
    s_axis_tdata = '0;
    sent_items = 0;
    next_gap = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: two points with full-scale values, both signs of the slope,
    // queries at the ends, just inside and beyond the span.
    write_point(0, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff);
    write_point(1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    query_at(32'h0000_0000);
    query_at(32'hffff_fffe);
    query_at(32'hffff_ffff);
    query_at(32'h8000_0000);
    query_at(32'h5555_5555);
    write_point(0, 32'h0001_0000, 32'h0100_0000, 32'hff00_0000);
    write_point(1, 32'h0001_0003, 32'h0100_0000, 32'hff00_0001);
    query_at(32'h0000_ffff);
    query_at(32'h0001_0001);
    query_at(32'h0001_0002);
    // Writes to a slot past the used count, then the full table size.
    write_point(255, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000);
    set_points(256);
    load_table(256, 32'h0000_0000, 60000);
    query_at(wl_shadow[254]);
    query_at(wl_shadow[255] - 1);
    query_at(wl_shadow[128]);
    // Out-of-range count values saturate.
    set_points(0);
    query_at(wl_shadow[0]);
    set_points(511);
    query_at(wl_shadow[255] - 1);

    // Random phases, mostly small tables with a few large ones.
    while (sent_items < 950) begin
      case ($urandom_range(0, 7))
        0: n = 256;
        1: n = $urandom_range(2, 256);
        default: n = $urandom_range(2, 12);
      endcase
      set_points((n == 256 && $urandom_range(0, 1)) ? 300 : n);
      load_table(n, $urandom_range(0, 1) ? 32'h0 : $urandom_range(0, 32'h7fff_ffff),
                 $urandom_range(0, 1) ? 8 : 2000000);
      repeat ($urandom_range(10, 40)) random_query();
    end

    idle_input();
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("table_linear_interpolator test passed");
    end else begin
      $display("table_linear_interpolator test failed");
    end
    $finish;
  end
endmodule
